### hw/rtl/tfp_pkg.sv
// shared types, constants and the output byte schedule of the frame parser
package tfp_pkg;

    // frame layout
    localparam int unsigned PAYLOAD_LEN = 14;
    localparam int unsigned ADDR_W      = 4;
    localparam logic [3:0]  POS_LAST    = 4'(PAYLOAD_LEN - 1);
    localparam logic [7:0]  CHECK_MASK  = 8'h7f;
    localparam logic [7:0]  END_CR      = 8'h0d;
    localparam logic [7:0]  END_LF      = 8'h0a;

    // register map
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic        REG_FIRST  = 1'b0;
    localparam logic        REG_SECOND = 1'b1;

    // parser phase
    typedef enum logic [2:0] {
        PH_HUNT0  = 3'd0,
        PH_HUNT1  = 3'd1,
        PH_DATA   = 3'd2,
        PH_CHECK  = 3'd3,
        PH_END_CR = 3'd4,
        PH_END_LF = 3'd5
    } phase_t;

    // output sequencer state
    typedef enum logic [1:0] {
        EM_IDLE = 2'd0,
        EM_READ = 2'd1,
        EM_LOAD = 2'd2
    } emit_t;

    typedef struct packed {
        logic [7:0] first_prefix;
        logic [7:0] second_prefix;
    } cfg_regs_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_req_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] lo_addr;
        logic [ADDR_W-1:0] hi_addr;
    } rd_req_t;

    typedef struct packed {
        logic       bypass;
        logic [2:0] shift;
    } repack_ctl_t;

    typedef struct packed {
        logic [ADDR_W-1:0] lo_addr;
        logic [ADDR_W-1:0] hi_addr;
        repack_ctl_t       ctl;
    } step_plan_t;

    // which stored bytes and which shift build output byte n
    function automatic step_plan_t step_plan(input logic [3:0] n);
        step_plan_t p;
        p.lo_addr    = n;
        p.hi_addr    = n;
        p.ctl.bypass = 1'b1;
        p.ctl.shift  = 3'd0;
        if (n >= 4'd9)
        begin
            p.lo_addr    = n - 4'd1;
            p.hi_addr    = n;
            p.ctl.bypass = 1'b0;
            p.ctl.shift  = 3'(n - 4'd9);
        end
        else if (n >= 4'd2)
        begin
            p.lo_addr    = n - 4'd2;
            p.hi_addr    = n - 4'd1;
            p.ctl.bypass = 1'b0;
            p.ctl.shift  = 3'(n - 4'd2);
        end
        return p;
    endfunction

endpackage

### hw/rtl/tfp_if.sv
// valid/ready word channels for received bytes and frame bytes
interface tfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfp_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [3:0] byte_position;
    logic       last_byte;

    modport source (output valid, output frame_byte, output byte_position,
                    output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input byte_position,
                    input last_byte, output ready);
endinterface

### hw/rtl/tag_frame_parser_7bit_unpack_top.sv
// Reader frame parser with 7-bit to 8-bit payload repacking.
//
// rx takes one received byte per word; frame delivers the 14 payload bytes
// of each good frame with their position and a last flag on byte 13.
// A frame is first_prefix, second_prefix, 14 payload bytes, a check byte
// (low 7 bits of the payload sum), 0x0D and 0x0A; any mismatch restarts
// the hunt for first_prefix. Prefixes are written over the APB port
// (first_prefix at 0x0, second_prefix at 0x4).
//
// While parsing, rx accepts one byte per cycle. The closing 0x0A starts the
// output sequencer, which walks the payload memory through one shared
// repack unit: for each byte, a READ state fetches two stored bytes and a
// LOAD state loads the output register once frame can take it. rx is held
// low during that walk. A stall on frame holds the output register and the
// sequencer waits on it; no byte is lost.
// Reset clears the prefixes to zero, returns to the hunt and empties the
// output register; the payload memory is not cleared.
module tag_frame_parser_7bit_unpack_top (
    input  logic                           clk,
    input  logic                           rst_n,
    tfp_rx_if.sink                         rx,
    tfp_frame_if.source                    frame,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tfp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    tfp_pkg::cfg_regs_t    cfg;
    tfp_pkg::wr_req_t      wr;
    tfp_pkg::rd_req_t      rd;
    tfp_pkg::step_plan_t   plan;
    tfp_pkg::repack_ctl_t  ctl_reg;
    logic [7:0]            lo_data;
    logic [7:0]            hi_data;
    logic [7:0]            repacked;

    tfp_pkg::phase_t       phase_reg, phase_next;
    logic [3:0]            count_reg, count_next;
    logic [7:0]            sum_reg, sum_next;
    logic [7:0]            check_reg, check_next;
    tfp_pkg::emit_t        emit_reg, emit_next;
    logic [3:0]            pos_reg, pos_next;

    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg;
    logic [3:0]            out_pos_reg;
    logic                  out_last_reg;
    logic                  out_load;
    logic                  rx_take;
    logic [7:0]            c;

    tfp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .regs    (cfg)
    );

    tfp_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .lo_data (lo_data),
        .hi_data (hi_data)
    );

    tfp_repack u_repack (
        .lo     (lo_data),
        .hi     (hi_data),
        .ctl    (ctl_reg),
        .result (repacked)
    );

    assign c        = rx.rx_byte;
    assign rx.ready = (emit_reg == tfp_pkg::EM_IDLE);
    assign rx_take  = rx.valid & rx.ready;

    // payload capture
    assign wr.en   = rx_take && (phase_reg == tfp_pkg::PH_DATA);
    assign wr.addr = count_reg;
    assign wr.data = c;

    // memory read for the current output byte
    assign plan       = tfp_pkg::step_plan(pos_reg);
    assign rd.en      = (emit_reg == tfp_pkg::EM_READ);
    assign rd.lo_addr = plan.lo_addr;
    assign rd.hi_addr = plan.hi_addr;

    // parser phase machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tfp_pkg::PH_HUNT0;
            count_reg <= 4'd0;
            sum_reg   <= 8'd0;
            check_reg <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            check_reg <= check_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        check_next = check_reg;
        if (rx_take)
        begin
            unique case (phase_reg)
                tfp_pkg::PH_HUNT1:
                begin
                    count_next = 4'd0;
                    sum_next   = 8'd0;
                    if (c == cfg.second_prefix)
                    begin
                        phase_next = tfp_pkg::PH_DATA;
                    end
                    else
                    begin
                        phase_next = tfp_pkg::PH_HUNT0;
                        check_next = 8'd0;
                    end
                end
                tfp_pkg::PH_DATA:
                begin
                    sum_next   = sum_reg + c;
                    count_next = count_reg + 4'd1;
                    if (count_reg == tfp_pkg::POS_LAST)
                    begin
                        phase_next = tfp_pkg::PH_CHECK;
                    end
                end
                tfp_pkg::PH_CHECK:
                begin
                    check_next = c;
                    phase_next = tfp_pkg::PH_END_CR;
                end
                tfp_pkg::PH_END_CR:
                begin
                    if (check_reg == (sum_reg & tfp_pkg::CHECK_MASK) && c == tfp_pkg::END_CR)
                    begin
                        phase_next = tfp_pkg::PH_END_LF;
                    end
                    else
                    begin
                        phase_next = tfp_pkg::PH_HUNT0;
                        count_next = 4'd0;
                        sum_next   = 8'd0;
                        check_next = 8'd0;
                    end
                end
                default:
                begin
                    // hunt for first prefix, also the end of frame
                    count_next = 4'd0;
                    sum_next   = 8'd0;
                    check_next = 8'd0;
                    if (phase_reg != tfp_pkg::PH_END_LF && c == cfg.first_prefix)
                    begin
                        phase_next = tfp_pkg::PH_HUNT1;
                    end
                    else
                    begin
                        phase_next = tfp_pkg::PH_HUNT0;
                    end
                end
            endcase
        end
    end

    // output sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg <= tfp_pkg::EM_IDLE;
            pos_reg  <= 4'd0;
        end
        else
        begin
            emit_reg <= emit_next;
            pos_reg  <= pos_next;
        end
    end

    assign out_load = (emit_reg == tfp_pkg::EM_LOAD) && (!out_valid_reg || frame.ready);

    always_comb
    begin
        emit_next = emit_reg;
        pos_next  = pos_reg;
        unique case (emit_reg)
            tfp_pkg::EM_IDLE:
            begin
                if (rx_take && phase_reg == tfp_pkg::PH_END_LF && c == tfp_pkg::END_LF)
                begin
                    emit_next = tfp_pkg::EM_READ;
                    pos_next  = 4'd0;
                end
            end
            tfp_pkg::EM_READ:
            begin
                emit_next = tfp_pkg::EM_LOAD;
            end
            tfp_pkg::EM_LOAD:
            begin
                if (out_load)
                begin
                    pos_next  = pos_reg + 4'd1;
                    emit_next = (pos_reg == tfp_pkg::POS_LAST) ? tfp_pkg::EM_IDLE
                                                               : tfp_pkg::EM_READ;
                end
            end
            default:
            begin
                emit_next = tfp_pkg::EM_IDLE;
            end
        endcase
    end

    // repack control is registered with the read, in step with the read data
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            ctl_reg <= plan.ctl;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (frame.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg <= repacked;
            out_pos_reg  <= pos_reg;
            out_last_reg <= (pos_reg == tfp_pkg::POS_LAST);
        end
    end

    assign frame.valid         = out_valid_reg;
    assign frame.frame_byte    = out_byte_reg;
    assign frame.byte_position = out_pos_reg;
    assign frame.last_byte     = out_last_reg;

endmodule

### hw/rtl/tfp_cfg.sv
// apb register file holding the two prefix bytes
module tfp_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tfp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output tfp_pkg::cfg_regs_t               regs
);

    logic [7:0] first_reg;
    logic [7:0] second_reg;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= 8'd0;
            second_reg <= 8'd0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                tfp_pkg::REG_FIRST:  first_reg  <= pwdata[7:0];
                tfp_pkg::REG_SECOND: second_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_sel)
            tfp_pkg::REG_FIRST:  prdata = {24'd0, first_reg};
            tfp_pkg::REG_SECOND: prdata = {24'd0, second_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign regs.first_prefix  = first_reg;
    assign regs.second_prefix = second_reg;

endmodule

### hw/rtl/tfp_store.sv
// payload memory: one write port, two registered read ports
module tfp_store (
    input  logic             clk,
    input  tfp_pkg::wr_req_t wr,
    input  tfp_pkg::rd_req_t rd,
    output logic [7:0]       lo_data,
    output logic [7:0]       hi_data
);

    logic [7:0] mem [tfp_pkg::PAYLOAD_LEN];
    logic [7:0] lo_reg;
    logic [7:0] hi_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read ports
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            lo_reg <= mem[rd.lo_addr];
            hi_reg <= mem[rd.hi_addr];
        end
    end

    assign lo_data = lo_reg;
    assign hi_data = hi_reg;

endmodule

### hw/rtl/tfp_repack.sv
// shared shift unit that merges two 7-bit groups into one byte, or passes lo through on bypass
module tfp_repack (
    input  logic [7:0]           lo,
    input  logic [7:0]           hi,
    input  tfp_pkg::repack_ctl_t ctl,
    output logic [7:0]           result
);

    logic [7:0]  mask;
    logic [14:0] merged;

    // keep shift+1 low bits of the upper byte
    assign mask   = ~(8'hff << (ctl.shift + 3'd1));
    assign merged = ({7'd0, lo} >> ctl.shift) | ({7'd0, hi & mask} << (3'd7 - ctl.shift));
    assign result = ctl.bypass ? lo : merged[7:0];

endmodule
